// File: rtl/iwc_pkg.sv
// ----------------------------------------------------------------------------
// iwc_pkg: shared definitions for the Wolff cluster update core
// Command codes, register indexes, field widths and the control structs
// passed between the sequencer and the random number unit.
// ----------------------------------------------------------------------------
`default_nettype none
package iwc_pkg;

	localparam int CMD_W   = 2;
	localparam int COORD_W = 7;
	localparam int SIZE_W  = 15;
	localparam int WORD_W  = 32;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_BOND_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED    = 1'd1;

	localparam logic [WORD_W-1:0] BOND_THRESHOLD_RST = 32'd2881094127;
	localparam logic [WORD_W-1:0] RANDOM_SEED_RST    = 32'd2463534242;

	// Request from the sequencer: advance the generator by one word.
	typedef struct packed {
		logic draw;
	} rng_ctl_t;

	// Answer for the current draw: the next word lies below the threshold.
	typedef struct packed {
		logic bond;
	} rng_stat_t;

endpackage
`default_nettype wire

// File: rtl/iwc_item_if.sv
// ----------------------------------------------------------------------------
// iwc_item_if: command channel
// Carries one command beat: command code, site coordinates and spin value.
// ----------------------------------------------------------------------------
`default_nettype none
interface iwc_item_if;
	logic                          valid;
	logic                          ready;
	logic [iwc_pkg::CMD_W-1:0]     command;
	logic [iwc_pkg::COORD_W-1:0]   site_x;
	logic [iwc_pkg::COORD_W-1:0]   site_y;
	logic                          spin_value;

	modport source (output valid, command, site_x, site_y, spin_value, input ready);
	modport sink   (input valid, command, site_x, site_y, spin_value, output ready);
endinterface
`default_nettype wire

// File: rtl/iwc_result_if.sv
// ----------------------------------------------------------------------------
// iwc_result_if: result channel
// Carries one result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none
interface iwc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         spin_read;
	logic [iwc_pkg::SIZE_W-1:0]   cluster_size;
	logic                         cluster_spin;
	logic [iwc_pkg::SIZE_W-1:0]   abs_total_spin;

	modport source (output valid, spin_read, cluster_size, cluster_spin, abs_total_spin,
		input ready);
	modport sink   (input valid, spin_read, cluster_size, cluster_spin, abs_total_spin,
		output ready);
endinterface
`default_nettype wire

// File: rtl/iwc_cfg_if.sv
// ----------------------------------------------------------------------------
// iwc_cfg_if: configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
`default_nettype none
interface iwc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [iwc_pkg::CFG_IDX_W-1:0]   index;
	logic [iwc_pkg::WORD_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/iwc_ram.sv
// ----------------------------------------------------------------------------
// iwc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module iwc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/iwc_rng.sv
// ----------------------------------------------------------------------------
// iwc_rng: bond random source
// Holds the configuration registers and the xorshift32 state, and answers
// whether the next drawn word falls below the bond threshold.
// ----------------------------------------------------------------------------
`default_nettype none
module iwc_rng (
	input  wire logic        clk,
	input  wire logic        arst_n,
	iwc_cfg_if.sink          cfg,
	input  iwc_pkg::rng_ctl_t  ctl,
	output iwc_pkg::rng_stat_t stat
);

	logic [iwc_pkg::WORD_W-1:0] thr_q;
	logic [iwc_pkg::WORD_W-1:0] gen_q;
	logic [iwc_pkg::WORD_W-1:0] t1, t2, gen_next;

	assign cfg.ready = 1'b1;

	always_comb begin
		t1       = gen_q ^ (gen_q << 13);
		t2       = t1 ^ (t1 >> 17);
		gen_next = t2 ^ (t2 << 5);
	end

	assign stat.bond = gen_next < thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= iwc_pkg::BOND_THRESHOLD_RST;
			gen_q <= iwc_pkg::RANDOM_SEED_RST;
		end else begin
			if (cfg.valid && cfg.index == iwc_pkg::REG_BOND_THRESHOLD) begin
				thr_q <= cfg.data;
			end
			if (cfg.valid && cfg.index == iwc_pkg::REG_RANDOM_SEED) begin
				gen_q <= cfg.data;
			end else if (ctl.draw) begin
				gen_q <= gen_next;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ising_wolff_cluster_update_core.sv
// ----------------------------------------------------------------------------
// ising_wolff_cluster_update_core: Wolff cluster update on a periodic lattice
// Site memory, cluster list memory and a sequencer that grows and flips one
// cluster breadth-first.
// ----------------------------------------------------------------------------
// A write, read or no-op command passes through the reduce, address, fetch,
// execute and done states, with one more reduce step per subtraction of SIDE
// while a coordinate is at least SIDE. An update of a cluster of N sites walks
// the single read port of the site memory once per neighbor (address, read and
// check states), plus list read and flip steps. One command is in flight at a time.
// After reset the site memory is swept once to set every
// spin to +1 and clear the marks; no command beat is taken during that sweep.
`default_nettype none
module ising_wolff_cluster_update_core #(
	parameter int SIDE = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	iwc_item_if.sink     item,
	iwc_result_if.source result,
	iwc_cfg_if.sink      cfg
);

	localparam int CW    = $clog2(SIDE);
	localparam int SITES = SIDE * SIDE;
	localparam int AW    = $clog2(SITES);
	localparam int NW    = $clog2(SITES + 1);
	localparam int TW    = NW + 1;
	localparam int XW    = (CW > iwc_pkg::COORD_W) ? CW : iwc_pkg::COORD_W;
	localparam int LW    = 2 * CW;

	// Each site word holds {visited, negative}; zero means spin +1, unmarked.
	localparam int SW = 2;

	typedef enum logic [14:0] {
		ST_CLEAR = 15'b000000000000001,
		ST_IDLE  = 15'b000000000000010,
		ST_RED   = 15'b000000000000100,
		ST_ADDR  = 15'b000000000001000,
		ST_FETCH = 15'b000000000010000,
		ST_EXEC  = 15'b000000000100000,
		ST_LIST  = 15'b000000001000000,
		ST_LWAIT = 15'b000000010000000,
		ST_NADDR = 15'b000000100000000,
		ST_NRD   = 15'b000001000000000,
		ST_NCHK  = 15'b000010000000000,
		ST_FRD   = 15'b000100000000000,
		ST_FWAIT = 15'b001000000000000,
		ST_FWR   = 15'b010000000000000,
		ST_DONE  = 15'b100000000000000
	} state_t;

	state_t state_q;

	iwc_pkg::cmd_t cmd_q;
	logic [XW-1:0] x_q, y_q;
	logic          val_q;
	logic [CW-1:0] cx_q, cy_q, nx_q, ny_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [NW-1:0] count_q, k_q, i_q;
	logic [1:0]    nb_q;
	logic          cspin_q;
	logic signed [TW-1:0] total_q;

	logic                      res_rd_q, res_cs_q;
	logic [iwc_pkg::SIZE_W-1:0] res_size_q;

	logic                      out_valid_q, out_rd_q, out_cs_q;
	logic [iwc_pkg::SIZE_W-1:0] out_size_q, out_abs_q;

	// Site memory ports.
	logic          s_we, s_re;
	logic [AW-1:0] s_waddr;
	logic [SW-1:0] s_wdata, s_rdata;
	// Cluster list memory ports.
	logic          l_we, l_re;
	logic [AW-1:0] l_waddr, l_raddr;
	logic [LW-1:0] l_wdata, l_rdata;

	iwc_pkg::rng_ctl_t  rng_ctl;
	iwc_pkg::rng_stat_t rng_stat;

	logic          like_free;
	logic [CW-1:0] nx_c, ny_c;
	logic signed [TW-1:0] abs_c;

	iwc_ram #(.WIDTH(SW), .DEPTH(SITES)) u_site_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(addr_q), .rdata(s_rdata)
	);

	iwc_ram #(.WIDTH(LW), .DEPTH(SITES)) u_list_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.re(l_re), .raddr(l_raddr), .rdata(l_rdata)
	);

	iwc_rng u_rng (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .ctl(rng_ctl), .stat(rng_stat)
	);

	assign item.ready = (state_q == ST_IDLE);

	assign result.valid          = out_valid_q;
	assign result.spin_read      = out_rd_q;
	assign result.cluster_size   = out_size_q;
	assign result.cluster_spin   = out_cs_q;
	assign result.abs_total_spin = out_abs_q;

	// A neighbor is a candidate when it carries the cluster spin and is unmarked.
	assign like_free = (~s_rdata[0] == cspin_q) && !s_rdata[1];

	assign abs_c = total_q[TW-1] ? -total_q : total_q;

	// Periodic neighbor coordinates in the order +x, +y, -x, -y.
	always_comb begin
		nx_c = cx_q;
		ny_c = cy_q;
		case (nb_q)
			2'd0: nx_c = (cx_q == CW'(SIDE - 1)) ? '0 : cx_q + 1'b1;
			2'd1: ny_c = (cy_q == CW'(SIDE - 1)) ? '0 : cy_q + 1'b1;
			2'd2: nx_c = (cx_q == '0) ? CW'(SIDE - 1) : cx_q - 1'b1;
			2'd3: ny_c = (cy_q == '0) ? CW'(SIDE - 1) : cy_q - 1'b1;
			default: nx_c = cx_q;
		endcase
	end

	// Memory and generator controls.
	always_comb begin
		s_we         = 1'b0;
		s_waddr      = addr_q;
		s_wdata      = '0;
		s_re         = 1'b0;
		l_we         = 1'b0;
		l_waddr      = count_q[AW-1:0];
		l_wdata      = {nx_q, ny_q};
		l_re         = 1'b0;
		l_raddr      = k_q[AW-1:0];
		rng_ctl.draw = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
			end
			ST_FETCH, ST_NRD: s_re = 1'b1;
			ST_EXEC: begin
				if (cmd_q == iwc_pkg::CMD_WRITE && s_rdata[0] == val_q) begin
					s_we    = 1'b1;
					s_wdata = {1'b0, ~val_q};
				end else if (cmd_q == iwc_pkg::CMD_UPDATE) begin
					s_we    = 1'b1;
					s_wdata = {1'b1, s_rdata[0]};
					l_we    = 1'b1;
					l_waddr = '0;
					l_wdata = {cx_q, cy_q};
				end
			end
			ST_LIST: l_re = (k_q != count_q);
			ST_NCHK: begin
				if (like_free) begin
					rng_ctl.draw = 1'b1;
					if (rng_stat.bond) begin
						s_we    = 1'b1;
						s_wdata = {1'b1, s_rdata[0]};
						l_we    = (count_q < NW'(SITES));
					end
				end
			end
			ST_FRD: begin
				l_re    = (i_q != count_q);
				l_raddr = i_q[AW-1:0];
			end
			ST_FWR: begin
				// The flipped spin is the opposite of the cluster spin.
				s_we    = 1'b1;
				s_wdata = {1'b0, cspin_q};
			end
			default: s_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			total_q     <= TW'(SITES);
			out_valid_q <= 1'b0;
			count_q     <= '0;
			k_q         <= '0;
			i_q         <= '0;
			nb_q        <= '0;
		end else begin
			if (result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(SITES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item.valid) begin
						cmd_q   <= iwc_pkg::cmd_t'(item.command);
						x_q     <= XW'(item.site_x);
						y_q     <= XW'(item.site_y);
						val_q   <= item.spin_value;
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					// Coordinates beyond the lattice wrap modulo SIDE.
					if ({1'b0, x_q} >= (XW + 1)'(SIDE)) begin
						x_q <= x_q - XW'(SIDE);
					end else if ({1'b0, y_q} >= (XW + 1)'(SIDE)) begin
						y_q <= y_q - XW'(SIDE);
					end else begin
						cx_q    <= x_q[CW-1:0];
						cy_q    <= y_q[CW-1:0];
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					addr_q  <= AW'(cx_q) * AW'(SIDE) + AW'(cy_q);
					state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					res_rd_q   <= (cmd_q == iwc_pkg::CMD_READ) ? ~s_rdata[0] : 1'b0;
					res_size_q <= '0;
					res_cs_q   <= 1'b0;
					state_q    <= (cmd_q == iwc_pkg::CMD_UPDATE) ? ST_LIST : ST_DONE;
					case (cmd_q)
						iwc_pkg::CMD_WRITE: begin
							if (s_rdata[0] == val_q) begin
								total_q <= val_q ? total_q + TW'(2) : total_q - TW'(2);
							end
						end
						iwc_pkg::CMD_UPDATE: begin
							cspin_q <= ~s_rdata[0];
							count_q <= NW'(1);
							k_q     <= '0;
							i_q     <= '0;
						end
						default: ;
					endcase
				end
				ST_LIST: begin
					if (k_q == count_q) begin
						i_q     <= '0;
						state_q <= ST_FRD;
					end else begin
						state_q <= ST_LWAIT;
					end
				end
				ST_LWAIT: begin
					cx_q    <= l_rdata[LW-1:CW];
					cy_q    <= l_rdata[CW-1:0];
					nb_q    <= '0;
					state_q <= ST_NADDR;
				end
				ST_NADDR: begin
					nx_q    <= nx_c;
					ny_q    <= ny_c;
					addr_q  <= AW'(nx_c) * AW'(SIDE) + AW'(ny_c);
					state_q <= ST_NRD;
				end
				ST_NRD: state_q <= ST_NCHK;
				ST_NCHK: begin
					if (like_free && rng_stat.bond && count_q < NW'(SITES)) begin
						count_q <= count_q + 1'b1;
					end
					nb_q <= nb_q + 1'b1;
					if (nb_q == 2'd3) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_LIST;
					end else begin
						state_q <= ST_NADDR;
					end
				end
				ST_FRD: begin
					if (i_q == count_q) begin
						total_q    <= cspin_q ? total_q - TW'({count_q, 1'b0})
							: total_q + TW'({count_q, 1'b0});
						res_rd_q   <= 1'b0;
						res_size_q <= iwc_pkg::SIZE_W'(count_q);
						res_cs_q   <= cspin_q;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_FWAIT;
					end
				end
				ST_FWAIT: begin
					addr_q  <= AW'(l_rdata[LW-1:CW]) * AW'(SIDE) + AW'(l_rdata[CW-1:0]);
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					i_q     <= i_q + 1'b1;
					state_q <= ST_FRD;
				end
				ST_DONE: begin
					// Hand the result to the output register once it is free.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= res_rd_q;
						out_size_q  <= res_size_q;
						out_cs_q    <= res_cs_q;
						out_abs_q   <= iwc_pkg::SIZE_W'(abs_c);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The cluster never holds more sites than the lattice.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(SITES))
		else $error("cluster count beyond lattice size");

	// The breadth-first cursor never passes the end of the list.
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= count_q)
		else $error("list cursor beyond cluster count");

	// The flip cursor never passes the end of the list.
	a_flip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= count_q)
		else $error("flip cursor beyond cluster count");

	// The running total stays within the possible spin sum.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q <= TW'(SITES)) && (total_q >= -TW'(SITES)))
		else $error("total spin out of range");

endmodule
`default_nettype wire
